### rtl/suffixed_decimal_parser_macros.svh
// Assertion macros for the suffixed decimal parser.
// Included by the top level; needs a clock named clock and a reset named reset.
`ifndef SUFFIXED_DECIMAL_PARSER_MACROS_SVH
`define SUFFIXED_DECIMAL_PARSER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SDP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define SDP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sdp_pkg.sv
// Shared types, constants and functions of the suffixed decimal parser.
// No dependencies; used by sdp_step and suffixed_decimal_parser.
package sdp_pkg;

   localparam int ValueW   = 31;
   localparam int CharW    = 8;
   localparam int PlacesW  = 3;
   localparam int DigitW   = 4;
   localparam int WeightW  = 17;
   localparam int FracAddW = 21;

   localparam int VALUE_MAX = 2147483647;
   localparam int K_LIMIT   = 2147483;
   localparam int M_LIMIT   = 2147;
   localparam int K_SCALE   = 1000;
   localparam int M_SCALE   = 1000000;
   localparam int K_PLACES  = 3;
   localparam int M_PLACES  = 6;

   localparam logic [CharW-1:0] CHAR_NUL  = 8'h00;
   localparam logic [CharW-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CharW-1:0] CHAR_NINE = 8'h39;
   localparam logic [CharW-1:0] CHAR_K_UP = 8'h4B;
   localparam logic [CharW-1:0] CHAR_K_LO = 8'h6B;
   localparam logic [CharW-1:0] CHAR_M_UP = 8'h4D;
   localparam logic [CharW-1:0] CHAR_M_LO = 8'h6D;

   // Parse phase, one-hot.
   typedef enum logic [3:0] {
      PH_INT  = 4'b0001,
      PH_FRAC = 4'b0010,
      PH_SKIP = 4'b0100,
      PH_BAD  = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type                phase;
      logic [ValueW-1:0]        acc;
      logic [PlacesW-1:0]       places;
   } sdp_state_type;

   localparam sdp_state_type STATE_RESET = '{phase: PH_INT, acc: '0, places: '0};

   // Place value of the suffix digit at the given index (places left minus one).
   function automatic logic [WeightW-1:0] place_weight(input logic [PlacesW-1:0] idx);
      logic [WeightW-1:0] w;
      case (idx)
         3'd0:    w = 17'd1;
         3'd1:    w = 17'd10;
         3'd2:    w = 17'd100;
         3'd3:    w = 17'd1000;
         3'd4:    w = 17'd10000;
         3'd5:    w = 17'd100000;
         default: w = 17'd0;
      endcase
      return w;
   endfunction

endpackage

### rtl/sdp_step.sv
// One character step of the suffixed decimal parser: next state and result.
// Purely combinational; depends on sdp_pkg.
module sdp_step (
   input  sdp_pkg::sdp_state_type     cur,
   input  logic [sdp_pkg::CharW-1:0]  char_code,
   output sdp_pkg::sdp_state_type     nxt,
   output logic [sdp_pkg::ValueW-1:0] res_value,
   output logic                       res_rejected
);
   import sdp_pkg::*;

   logic                  is_digit;
   logic                  is_k;
   logic                  is_m;
   logic [DigitW-1:0]     digit;
   logic [ValueW+3:0]     int_sum;
   logic [31:0]           k_prod;
   logic [31:0]           m_prod;
   logic [FracAddW-1:0]   frac_add;
   logic [31:0]           frac_sum;
   logic [PlacesW-1:0]    places_dec;

   // Classify the character and form the candidate values.
   always_comb begin
      is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      is_k       = (char_code == CHAR_K_UP) || (char_code == CHAR_K_LO);
      is_m       = (char_code == CHAR_M_UP) || (char_code == CHAR_M_LO);
      digit      = is_digit ? DigitW'(char_code - CHAR_ZERO) : '0;
      int_sum    = (ValueW+4)'({cur.acc, 3'b000}) + (ValueW+4)'({cur.acc, 1'b0})
                   + (ValueW+4)'(digit);
      k_prod     = 32'(cur.acc[21:0]) * 32'(K_SCALE);
      m_prod     = 32'(cur.acc[11:0]) * 32'(M_SCALE);
      places_dec = cur.places - 3'd1;
      frac_add   = FracAddW'(digit) * FracAddW'(place_weight(places_dec));
      frac_sum   = 32'(cur.acc) + 32'(frac_add);
   end

   // Advance the parse state; a terminator emits the result and clears.
   always_comb begin
      nxt          = cur;
      res_value    = '0;
      res_rejected = 1'b0;
      if (char_code == CHAR_NUL) begin
         res_rejected = (cur.phase == PH_BAD);
         res_value    = (cur.phase == PH_BAD) ? '0 : cur.acc;
         nxt          = STATE_RESET;
      end else begin
         case (cur.phase)
            PH_INT: begin
               if (is_digit) begin
                  if (int_sum > (ValueW+4)'(VALUE_MAX)) nxt.phase = PH_BAD;
                  else nxt.acc = int_sum[ValueW-1:0];
               end else if (is_k) begin
                  if (cur.acc > ValueW'(K_LIMIT)) begin
                     nxt.phase = PH_BAD;
                  end else begin
                     nxt.acc    = k_prod[ValueW-1:0];
                     nxt.places = PlacesW'(K_PLACES);
                     nxt.phase  = PH_FRAC;
                  end
               end else if (is_m) begin
                  if (cur.acc > ValueW'(M_LIMIT)) begin
                     nxt.phase = PH_BAD;
                  end else begin
                     nxt.acc    = m_prod[ValueW-1:0];
                     nxt.places = PlacesW'(M_PLACES);
                     nxt.phase  = PH_FRAC;
                  end
               end else begin
                  nxt.phase = PH_BAD;
               end
            end
            PH_FRAC: begin
               if (!is_digit) begin
                  nxt.phase = PH_BAD;
               end else if (cur.places == '0 || cur.places > PlacesW'(M_PLACES)) begin
                  nxt.phase = PH_SKIP;
               end else if (frac_sum > 32'(VALUE_MAX)) begin
                  nxt.phase = PH_BAD;
               end else begin
                  nxt.acc    = frac_sum[ValueW-1:0];
                  nxt.places = places_dec;
               end
            end
            default: begin
               // Skipping the tail or rejected: hold until the terminator.
               nxt = cur;
            end
         endcase
      end
   end

endmodule

### rtl/suffixed_decimal_parser.sv
// Suffixed decimal parser: one ASCII character per transfer in, one result per string out.
// Depends on sdp_pkg, sdp_step and suffixed_decimal_parser_macros.svh.
//
// Characters arrive one per req transfer; a zero byte ends the string and
// produces one rsp transfer carrying the value (0 when rejected) and the
// rejected flag. Digits build an integer, a single k/K or m/M scales it by
// 1000 or 1000000, and up to 3 or 6 following digits fill the lower places.
// The block takes one character every cycle while it is not stalled. A terminator
// passes through the input register and then the parse step, which loads the
// result register. The only stall comes from the result channel: a terminator
// waits in the input register while an earlier result is still held there.
`include "suffixed_decimal_parser_macros.svh"

module suffixed_decimal_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sdp_pkg::CharW-1:0]           req_tdata,  // [7:0] char_code
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,  // [30:0] value, [31] zero
   output logic                                rsp_tuser   // [0] rejected
);
   import sdp_pkg::*;

   logic                 in_valid_ff;
   logic [CharW-1:0]     in_char_ff;
   sdp_state_type        state_ff;
   sdp_state_type        state_in;
   logic                 rsp_valid_ff;
   logic [ValueW-1:0]    rsp_value_ff;
   logic                 rsp_rejected_ff;
   logic [ValueW-1:0]    step_value;
   logic                 step_rejected;
   logic                 in_is_term;
   logic                 out_free;
   logic                 step_fire;

   // Handshake: a terminator needs room in the result register.
   assign in_is_term = (in_char_ff == CHAR_NUL);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_fire  = in_valid_ff && (!in_is_term || out_free);
   assign req_tready = !in_valid_ff || step_fire;

   // Capture the incoming character.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
      end
   end

   sdp_step u_step (
      .cur          (state_ff),
      .char_code    (in_char_ff),
      .nxt          (state_in),
      .res_value    (step_value),
      .res_rejected (step_rejected)
   );

   // Advance the parse state on each processed character.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // Load the result on a terminator; drop it once transferred.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_fire && in_is_term) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && in_is_term) begin
         rsp_value_ff    <= step_value;
         rsp_rejected_ff <= step_rejected;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_value_ff};
   assign rsp_tuser  = rsp_rejected_ff;

   // Checks on the parser's own state and result path.
   `SDP_ASSERT_NEXT(a_term_clears, step_fire && in_is_term, state_ff == STATE_RESET, "state not cleared after terminator")
   `SDP_ASSERT_SAME(a_frac_places, state_ff.phase == PH_FRAC, state_ff.places <= PlacesW'(M_PLACES), "suffix places out of range")
   `SDP_ASSERT_SAME(a_reject_zero, rsp_valid_ff && rsp_rejected_ff, rsp_value_ff == '0, "rejected result carries a value")
   `SDP_ASSERT_NEXT(a_load_source, !rsp_valid_ff && !(step_fire && in_is_term), !rsp_valid_ff, "result appeared without terminator")

endmodule
